### src/qva_pkg.sv
// ----------------------------------------------------------------------------
// qva_pkg
// Shared widths, operation codes and transaction side-band types for the
// quaternion / vector ALU pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qva_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int OP_W          = 3;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RAD_W  = PROD_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 4;

  localparam int NUM_BASE = ((WORD_BITS + FRACTION_BITS > 2 * WORD_BITS - FRACTION_BITS) ?
                             (WORD_BITS + FRACTION_BITS) :
                             (2 * WORD_BITS - FRACTION_BITS)) + 2;
  localparam int NUM_W     = NUM_BASE + (NUM_BASE % 2);
  localparam int DEN_W     = NUM_W;
  localparam int DIV_STEPS = NUM_W / 2;

  localparam logic [OP_W-1:0] OP_QMUL   = 3'd0;
  localparam logic [OP_W-1:0] OP_QSCALE = 3'd1;
  localparam logic [OP_W-1:0] OP_QINV   = 3'd2;
  localparam logic [OP_W-1:0] OP_QNORM  = 3'd3;
  localparam logic [OP_W-1:0] OP_CROSS  = 3'd4;
  localparam logic [OP_W-1:0] OP_VNORM  = 3'd5;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t ONE_WORD = WORD_BITS'(1) << FRACTION_BITS;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    word_t [3:0]      a;
    word_t [3:0]      r;
    logic             sat;
    logic             n2_zero;
    logic [DEN_W-1:0] n2;
  } root_side_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    word_t [3:0]     r;
    logic            sat;
    logic            degen;
    logic [3:0]      neg;
  } div_side_t;

endpackage

`default_nettype wire

### src/quaternion_vector_alu_core.sv
// ----------------------------------------------------------------------------
// quaternion_vector_alu_core
// Fixed-point quaternion and 3-vector ALU: Hamilton product, scale, inverse,
// normalize, cross product and vector normalize on signed Q16.16 words.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while no result waits under rsp_stall and
// returns one result per transaction, in order. Every operation runs the same
// pipeline: 3 front stages (products, sums, rounding), the square-root
// extractor (one root bit per stage of a 66-bit radicand), the radix-4
// divider (two quotient bits per stage of a 50-bit numerator) and the output
// register. The whole pipeline holds while a result waits under rsp_stall.
`default_nettype none

module quaternion_vector_alu_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [qva_pkg::OP_W-1:0]  operation,
  input  qva_pkg::word_t            a_w,
  input  qva_pkg::word_t            a_x,
  input  qva_pkg::word_t            a_y,
  input  qva_pkg::word_t            a_z,
  input  qva_pkg::word_t            b_w,
  input  qva_pkg::word_t            b_x,
  input  qva_pkg::word_t            b_y,
  input  qva_pkg::word_t            b_z,
  input  qva_pkg::word_t            scale_factor,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output qva_pkg::word_t            r_w,
  output qva_pkg::word_t            r_x,
  output qva_pkg::word_t            r_y,
  output qva_pkg::word_t            r_z,
  output logic                      degenerate,
  output logic                      saturated
);

  logic                                en;
  logic                                front_valid, root_valid, div_valid;
  logic [qva_pkg::RAD_W-1:0]           radicand;
  qva_pkg::root_side_t                 front_side, root_side;
  logic [qva_pkg::ROOT_W-1:0]          root;
  logic [3:0][qva_pkg::NUM_W-1:0]      quot;
  qva_pkg::div_side_t                  div_side;

  assign en        = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  qva_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (req_valid),
    .operation    (operation),
    .a            ({a_z, a_y, a_x, a_w}),
    .b            ({b_z, b_y, b_x, b_w}),
    .scale_factor (scale_factor),
    .out_valid    (front_valid),
    .radicand     (radicand),
    .side         (front_side)
  );

  qva_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .radicand  (radicand),
    .side_in   (front_side),
    .out_valid (root_valid),
    .root      (root),
    .side_out  (root_side)
  );

  qva_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .root      (root),
    .side_in   (root_side),
    .out_valid (div_valid),
    .quot      (quot),
    .side_out  (div_side)
  );

  qva_result u_result (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (div_valid),
    .quot       (quot),
    .side       (div_side),
    .out_valid  (rsp_valid),
    .r_w        (r_w),
    .r_x        (r_x),
    .r_y        (r_y),
    .r_z        (r_z),
    .degenerate (degenerate),
    .saturated  (saturated)
  );

endmodule

`default_nettype wire

### src/qva_front.sv
// ----------------------------------------------------------------------------
// qva_front
// Operand select and product array, exact sums of products, then rounding,
// clamping, squared norm and radicand select. Three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qva_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qva_pkg::OP_W-1:0]      operation,
  input  qva_pkg::word_t [3:0]          a,
  input  qva_pkg::word_t [3:0]          b,
  input  qva_pkg::word_t                scale_factor,
  output logic                          out_valid,
  output logic [qva_pkg::RAD_W-1:0]     radicand,
  output qva_pkg::root_side_t           side
);

  localparam int SUM_W = qva_pkg::SUM_W;
  localparam int RAD_W = qva_pkg::RAD_W;
  localparam int F     = qva_pkg::FRACTION_BITS;
  localparam int W     = qva_pkg::WORD_BITS;

  localparam logic signed [SUM_W-1:0] S_HALF = SUM_W'(1) <<< (F - 1);
  localparam logic signed [SUM_W-1:0] S_MAX  =
    $signed({{(SUM_W-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] S_MIN  = ~S_MAX;
  localparam logic [RAD_W-1:0] R_HALF = RAD_W'(1) << (F - 1);

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [qva_pkg::PROD_W-1:0] p);
    return SUM_W'(p);
  endfunction

  // stage 1
  qva_pkg::word_t [3:0]                    m_sel;
  logic signed [qva_pkg::PROD_W-1:0]       p [4][4];
  logic [qva_pkg::OP_W-1:0]                op1;
  qva_pkg::word_t [3:0]                    a1;
  // stage 2
  logic signed [SUM_W-1:0]                 s_next [4];
  logic [RAD_W-1:0]                        sq4_next, sq3_next;
  logic signed [SUM_W-1:0]                 s2 [4];
  logic [RAD_W-1:0]                        sq4, sq3;
  logic [qva_pkg::OP_W-1:0]                op2;
  qva_pkg::word_t [3:0]                    a2;
  // stage 3
  logic signed [SUM_W-1:0]                 rnd [4];
  qva_pkg::word_t [3:0]                    r_next;
  logic [3:0]                              lane_sat;
  logic [RAD_W-1:0]                        n2_full;
  logic [2:0]                              v;

  always_comb begin
    case (operation) inside
      qva_pkg::OP_QMUL, qva_pkg::OP_CROSS: m_sel = b;
      qva_pkg::OP_QSCALE:                  m_sel = {4{scale_factor}};
      default:                             m_sel = a;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) s_next[i] = '0;
    case (op1)
      qva_pkg::OP_QMUL: begin
        s_next[0] = sx(p[0][0]) - sx(p[1][1]) - sx(p[2][2]) - sx(p[3][3]);
        s_next[1] = sx(p[0][1]) + sx(p[1][0]) + sx(p[2][3]) - sx(p[3][2]);
        s_next[2] = sx(p[0][2]) - sx(p[1][3]) + sx(p[2][0]) + sx(p[3][1]);
        s_next[3] = sx(p[0][3]) + sx(p[1][2]) - sx(p[2][1]) + sx(p[3][0]);
      end
      qva_pkg::OP_QSCALE: begin
        for (int i = 0; i < 4; i++) s_next[i] = sx(p[i][i]);
      end
      qva_pkg::OP_CROSS: begin
        s_next[1] = sx(p[2][3]) - sx(p[3][2]);
        s_next[2] = sx(p[3][1]) - sx(p[1][3]);
        s_next[3] = sx(p[1][2]) - sx(p[2][1]);
      end
      default: ;
    endcase
    sq3_next = RAD_W'($unsigned(p[1][1])) + RAD_W'($unsigned(p[2][2]))
             + RAD_W'($unsigned(p[3][3]));
    sq4_next = sq3_next + RAD_W'($unsigned(p[0][0]));
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd[i]      = (s2[i] + S_HALF) >>> F;
      lane_sat[i] = (rnd[i] > S_MAX) || (rnd[i] < S_MIN);
      if (rnd[i] > S_MAX)      r_next[i] = qva_pkg::WORD_MAX;
      else if (rnd[i] < S_MIN) r_next[i] = qva_pkg::WORD_MIN;
      else                     r_next[i] = rnd[i][W-1:0];
    end
    n2_full = (sq4 + R_HALF) >> F;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p[i][j] <= $signed(a[i]) * $signed(m_sel[j]);
        end
      end
      op1 <= operation;
      a1  <= a;
      for (int i = 0; i < 4; i++) s2[i] <= s_next[i];
      sq4 <= sq4_next;
      sq3 <= sq3_next;
      op2 <= op1;
      a2  <= a1;
      side.op      <= op2;
      side.a       <= a2;
      side.r       <= r_next;
      side.sat     <= |lane_sat;
      side.n2      <= qva_pkg::DEN_W'(n2_full);
      side.n2_zero <= (n2_full == '0);
      radicand     <= (op2 == qva_pkg::OP_VNORM) ? sq3 : sq4;
    end
  end

  assign out_valid = v[2];

endmodule

`default_nettype wire

### src/qva_sqrt.sv
// ----------------------------------------------------------------------------
// qva_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qva_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [qva_pkg::RAD_W-1:0]      radicand,
  input  qva_pkg::root_side_t            side_in,
  output logic                           out_valid,
  output logic [qva_pkg::ROOT_W-1:0]     root,
  output qva_pkg::root_side_t            side_out
);

  localparam int N     = qva_pkg::ROOT_W;
  localparam int RAD_W = qva_pkg::RAD_W;
  localparam int REM_W = qva_pkg::REM_W;

  logic [REM_W-1:0]    rem_q  [N+1];
  logic [N-1:0]        root_q [N+1];
  logic [RAD_W-1:0]    rad_q  [N+1];
  qva_pkg::root_side_t side_q [N+1];
  logic [N:0]          v;

  logic [REM_W-1:0]    rem_nx  [N];
  logic [N-1:0]        root_nx [N];

  always_comb begin
    logic [REM_W-1:0] t, trial;
    for (int k = 0; k < N; k++) begin
      t     = {rem_q[k][REM_W-3:0], rad_q[k][RAD_W-1 -: 2]};
      trial = REM_W'({root_q[k], 2'b01});
      if (t >= trial) begin
        rem_nx[k]  = t - trial;
        root_nx[k] = {root_q[k][N-2:0], 1'b1};
      end else begin
        rem_nx[k]  = t;
        root_nx[k] = {root_q[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      rad_q[0]  <= radicand;
      side_q[0] <= side_in;
      for (int k = 0; k < N; k++) begin
        rem_q[k+1]  <= rem_nx[k];
        root_q[k+1] <= root_nx[k];
        rad_q[k+1]  <= {rad_q[k][RAD_W-3:0], 2'b00};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = v[N];
  assign root      = root_q[N];
  assign side_out  = side_q[N];

endmodule

`default_nettype wire

### src/qva_div.sv
// ----------------------------------------------------------------------------
// qva_div
// Divisor and numerator setup, then four lanes of pipelined radix-4
// restoring division sharing one divisor, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qva_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [qva_pkg::ROOT_W-1:0]          root,
  input  qva_pkg::root_side_t                 side_in,
  output logic                                out_valid,
  output logic [3:0][qva_pkg::NUM_W-1:0]      quot,
  output qva_pkg::div_side_t                  side_out
);

  localparam int N     = qva_pkg::DIV_STEPS;
  localparam int NUM_W = qva_pkg::NUM_W;
  localparam int DEN_W = qva_pkg::DEN_W;
  localparam int W     = qva_pkg::WORD_BITS;
  localparam int F     = qva_pkg::FRACTION_BITS;

  localparam logic [DEN_W-1:0] ONE_DEN = DEN_W'(1) << F;

  logic [DEN_W-1:0]        d_set;
  logic                    degen_set;
  qva_pkg::word_t [3:0]    x_sel;
  logic [W:0]              mag [4];
  logic [3:0]              neg_set;
  logic [NUM_W-1:0]        num_set [4];

  logic [DEN_W-1:0]        d_q   [N+1];
  logic [DEN_W+1:0]        d3_q  [N+1];
  logic [DEN_W-1:0]        rem_q [N+1][4];
  logic [NUM_W-1:0]        num_q [N+1][4];
  qva_pkg::div_side_t      side_q [N+1];
  logic [N:0]              v;

  logic [DEN_W-1:0]        rem_nx [N][4];
  logic [NUM_W-1:0]        num_nx [N][4];

  always_comb begin
    if (side_in.op == qva_pkg::OP_QINV) begin
      degen_set = side_in.n2_zero;
      d_set     = side_in.n2_zero ? ONE_DEN : side_in.n2;
    end else begin
      degen_set = ((side_in.op == qva_pkg::OP_QNORM) || (side_in.op == qva_pkg::OP_VNORM))
                  && (root == '0);
      d_set     = DEN_W'(root);
    end
    x_sel = side_in.a;
    if (side_in.op == qva_pkg::OP_VNORM) x_sel[0] = '0;
    for (int i = 0; i < 4; i++) begin
      neg_set[i] = x_sel[i][W-1] ^ ((side_in.op == qva_pkg::OP_QINV) && (i != 0));
      mag[i]     = x_sel[i][W-1] ? ((W+1)'(0) - {x_sel[i][W-1], x_sel[i]})
                                 : {1'b0, x_sel[i]};
      num_set[i] = (NUM_W'(mag[i]) << F) + NUM_W'(d_set >> 1);
    end
  end

  always_comb begin
    logic [DEN_W+1:0] t, d1, d2, sub;
    logic [1:0]       dig;
    for (int k = 0; k < N; k++) begin
      d1 = (DEN_W+2)'(d_q[k]);
      d2 = d1 << 1;
      for (int i = 0; i < 4; i++) begin
        t = {rem_q[k][i], num_q[k][i][NUM_W-1 -: 2]};
        if (t >= d3_q[k]) begin
          dig = 2'd3;
          sub = d3_q[k];
        end else if (t >= d2) begin
          dig = 2'd2;
          sub = d2;
        end else if (t >= d1) begin
          dig = 2'd1;
          sub = d1;
        end else begin
          dig = 2'd0;
          sub = '0;
        end
        rem_nx[k][i] = DEN_W'(t - sub);
        num_nx[k][i] = {num_q[k][i][NUM_W-3:0], dig};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_q[0]          <= d_set;
      d3_q[0]         <= (DEN_W+2)'(d_set) + ((DEN_W+2)'(d_set) << 1);
      side_q[0].op    <= side_in.op;
      side_q[0].r     <= side_in.r;
      side_q[0].sat   <= side_in.sat;
      side_q[0].degen <= degen_set;
      side_q[0].neg   <= neg_set;
      for (int i = 0; i < 4; i++) begin
        rem_q[0][i] <= '0;
        num_q[0][i] <= num_set[i];
      end
      for (int k = 0; k < N; k++) begin
        d_q[k+1]    <= d_q[k];
        d3_q[k+1]   <= d3_q[k];
        side_q[k+1] <= side_q[k];
        for (int i = 0; i < 4; i++) begin
          rem_q[k+1][i] <= rem_nx[k][i];
          num_q[k+1][i] <= num_nx[k][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) quot[i] = num_q[N][i];
  end

  assign out_valid = v[N];
  assign side_out  = side_q[N];

endmodule

`default_nettype wire

### src/qva_result.sv
// ----------------------------------------------------------------------------
// qva_result
// Quotient sign and clamp, fallback results, per-operation select and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qva_result (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [3:0][qva_pkg::NUM_W-1:0]  quot,
  input  qva_pkg::div_side_t              side,
  output logic                            out_valid,
  output qva_pkg::word_t                  r_w,
  output qva_pkg::word_t                  r_x,
  output qva_pkg::word_t                  r_y,
  output qva_pkg::word_t                  r_z,
  output logic                            degenerate,
  output logic                            saturated
);

  localparam int NUM_W = qva_pkg::NUM_W;
  localparam int W     = qva_pkg::WORD_BITS;

  localparam logic [NUM_W-1:0] LIM_POS = NUM_W'($unsigned(qva_pkg::WORD_MAX));
  localparam logic [NUM_W-1:0] LIM_NEG = LIM_POS + NUM_W'(1);

  logic [3:0]           qsat;
  qva_pkg::word_t [3:0] qval;
  qva_pkg::word_t [3:0] r_nx;
  logic                 deg_nx, sat_nx;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qsat[i] = side.neg[i] ? (quot[i] > LIM_NEG) : (quot[i] > LIM_POS);
      if (qsat[i])          qval[i] = side.neg[i] ? qva_pkg::WORD_MIN : qva_pkg::WORD_MAX;
      else if (side.neg[i]) qval[i] = -quot[i][W-1:0];
      else                  qval[i] = quot[i][W-1:0];
    end
    r_nx   = '0;
    deg_nx = 1'b0;
    sat_nx = 1'b0;
    case (side.op) inside
      qva_pkg::OP_QMUL, qva_pkg::OP_QSCALE, qva_pkg::OP_CROSS: begin
        r_nx   = side.r;
        sat_nx = side.sat;
      end
      qva_pkg::OP_QINV: begin
        r_nx   = qval;
        sat_nx = |qsat;
        deg_nx = side.degen;
      end
      qva_pkg::OP_QNORM, qva_pkg::OP_VNORM: begin
        deg_nx = side.degen;
        if (side.degen) begin
          if (side.op == qva_pkg::OP_QNORM) r_nx[0] = qva_pkg::ONE_WORD;
        end else begin
          r_nx   = qval;
          sat_nx = |qsat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_w        <= r_nx[0];
      r_x        <= r_nx[1];
      r_y        <= r_nx[2];
      r_z        <= r_nx[3];
      degenerate <= deg_nx;
      saturated  <= sat_nx;
    end
  end

endmodule

`default_nettype wire

### src/qva_checker.sv
// ----------------------------------------------------------------------------
// qva_checker
// Port-level checks on the ALU core: reset, backpressure and the meaning of
// the saturated flag.
// ----------------------------------------------------------------------------
`default_nettype none

module qva_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input qva_pkg::word_t r_w,
  input qva_pkg::word_t r_x,
  input qva_pkg::word_t r_y,
  input qva_pkg::word_t r_z,
  input logic           degenerate,
  input logic           saturated
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_stall_only_backpressure: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without output backpressure");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(r_w) && $stable(r_x) &&
      $stable(r_y) && $stable(r_z) && $stable(degenerate) && $stable(saturated)))
    else $error("stalled result transaction changed");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && saturated) |->
      (r_w == qva_pkg::WORD_MAX || r_w == qva_pkg::WORD_MIN ||
       r_x == qva_pkg::WORD_MAX || r_x == qva_pkg::WORD_MIN ||
       r_y == qva_pkg::WORD_MAX || r_y == qva_pkg::WORD_MIN ||
       r_z == qva_pkg::WORD_MAX || r_z == qva_pkg::WORD_MIN))
    else $error("saturated set with no clamped component");

endmodule

bind quaternion_vector_alu_core qva_checker u_qva_checker (.*);

`default_nettype wire
